// File: rtl/core/hte_pkg.sv
`timescale 1ns / 1ps
package hte_pkg;

  localparam int FracBits = 16;
  localparam int WordWidth = 32;
  localparam int AccWidth = 72;

  typedef logic signed [WordWidth-1:0] word_t;
  typedef logic signed [AccWidth-1:0] acc_t;

  typedef enum logic [3:0] {
    REQ_CLEAR     = 4'd0,
    REQ_IDENTITY  = 4'd1,
    REQ_SET       = 4'd2,
    REQ_GET       = 4'd3,
    REQ_TRANSLATE = 4'd4,
    REQ_SCALE     = 4'd5,
    REQ_ROTX      = 4'd6,
    REQ_ROTY      = 4'd7,
    REQ_ROTZ      = 4'd8,
    REQ_SHEAR2D   = 4'd9,
    REQ_SHEARZ    = 4'd10,
    REQ_PERSP     = 4'd11,
    REQ_TRANSFORM = 4'd12,
    REQ_TRANSPOSE = 4'd13
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_MAC,
    ST_ROUND,
    ST_COPY,
    ST_DONE
  } state_t;

  localparam word_t WordMax = {1'b0, {(WordWidth-1){1'b1}}};
  localparam word_t WordMin = {1'b1, {(WordWidth-1){1'b0}}};
  localparam word_t OneValue = word_t'(64'sd1 <<< FracBits);

endpackage

// File: rtl/core/homogeneous_transform_engine_core.sv
`timescale 1ns / 1ps
// Keeps a 4x4 Q16.16 transform matrix (identity after reset) and serves one request at a time.
// Premultiplying matrix updates and point transforms share one 32x32 multiply-accumulate unit:
// a premultiply computes 16 dot products of 4 terms and then copies the result into the matrix;
// a transform computes 4 dot products; perspective first runs a bit-serial reciprocal; other
// requests finish without the unit. tready is low while a request runs.
module homogeneous_transform_engine_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // req_type[3:0], row_index[5:4], col_index[7:6], operand_a[39:8], operand_b[71:40],
  // operand_c[103:72], operand_d[135:104]
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96], saturated[128]
  output logic [135:0] m_tdata
);

  hte_pkg::state_t state, state_next;
  hte_pkg::word_t mat [16];
  hte_pkg::word_t tmp [16];
  hte_pkg::word_t lmat [16];
  hte_pkg::word_t res [4];
  hte_pkg::word_t opa, opb, opc, opd, nsin;
  logic [3:0] req;
  logic [1:0] row, col;
  logic flag;
  logic [3:0] elem;
  logic [1:0] kidx;
  logic is_xform;
  hte_pkg::acc_t acc;
  logic signed [63:0] prod;
  hte_pkg::word_t mul_a, mul_b;
  logic signed [hte_pkg::AccWidth-1:0] rnd;
  hte_pkg::word_t rnd_word;
  logic rnd_sat;
  logic prod_valid;
  logic issue_done;
  logic recip_start, recip_busy, recip_done, recip_sat;
  hte_pkg::word_t recip_val;
  logic accept;
  logic [3:0] in_req;

  assign in_req = s_tdata[3:0];
  assign s_tready = (state == hte_pkg::ST_IDLE);
  assign accept = s_tvalid && s_tready;
  assign recip_start = accept && in_req == hte_pkg::REQ_PERSP;

  hte_recip u_recip (
    .clk(clk), .rst(rst), .start(recip_start), .d(s_tdata[39:8]),
    .busy(recip_busy), .done(recip_done), .result(recip_val), .sat(recip_sat)
  );

  always_comb begin
    for (int i = 0; i < 16; i++) lmat[i] = (i % 5 == 0) ? hte_pkg::OneValue : '0;
    nsin = (opb == hte_pkg::WordMin) ? hte_pkg::WordMax : -opb;
    case (req)
      hte_pkg::REQ_TRANSLATE: begin
        lmat[3] = opa; lmat[7] = opb; lmat[11] = opc;
      end
      hte_pkg::REQ_SCALE: begin
        lmat[0] = opa; lmat[5] = opb; lmat[10] = opc;
      end
      hte_pkg::REQ_ROTX: begin
        lmat[5] = opa; lmat[6] = nsin; lmat[9] = opb; lmat[10] = opa;
      end
      hte_pkg::REQ_ROTY: begin
        lmat[0] = opa; lmat[2] = opb; lmat[8] = nsin; lmat[10] = opa;
      end
      hte_pkg::REQ_ROTZ: begin
        lmat[0] = opa; lmat[1] = nsin; lmat[4] = opb; lmat[5] = opa;
      end
      hte_pkg::REQ_SHEAR2D: begin
        lmat[1] = opa; lmat[4] = opb;
      end
      hte_pkg::REQ_SHEARZ: begin
        lmat[2] = opa; lmat[6] = opb;
      end
      hte_pkg::REQ_PERSP: begin
        lmat[14] = opd; lmat[15] = '0;
      end
      default: ;
    endcase
  end

  // elem = {i, j}; for transforms elem[1:0] is the output row
  always_comb begin
    if (is_xform) begin
      mul_a = mat[{elem[1:0], kidx}];
      case (kidx)
        2'd0: mul_b = opa;
        2'd1: mul_b = opb;
        2'd2: mul_b = opc;
        default: mul_b = opd;
      endcase
    end else begin
      mul_a = lmat[{elem[3:2], kidx}];
      mul_b = mat[{kidx, elem[1:0]}];
    end
  end

  always_comb begin
    rnd = (acc + hte_pkg::acc_t'(1 <<< (hte_pkg::FracBits - 1))) >>> hte_pkg::FracBits;
    rnd_sat = 1'b0;
    rnd_word = rnd[hte_pkg::WordWidth-1:0];
    if (rnd > hte_pkg::acc_t'(hte_pkg::WordMax)) begin
      rnd_sat = 1'b1; rnd_word = hte_pkg::WordMax;
    end else if (rnd < hte_pkg::acc_t'(hte_pkg::WordMin)) begin
      rnd_sat = 1'b1; rnd_word = hte_pkg::WordMin;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      hte_pkg::ST_IDLE:
        if (accept && in_req <= hte_pkg::REQ_TRANSPOSE) begin
          if (in_req == hte_pkg::REQ_PERSP) state_next = hte_pkg::ST_RECIP;
          else if (in_req >= hte_pkg::REQ_TRANSLATE && in_req <= hte_pkg::REQ_TRANSFORM)
            state_next = hte_pkg::ST_MAC;
          else state_next = hte_pkg::ST_DONE;
        end
      hte_pkg::ST_RECIP: if (recip_done) state_next = hte_pkg::ST_MAC;
      hte_pkg::ST_MAC: if (issue_done && prod_valid) state_next = hte_pkg::ST_ROUND;
      hte_pkg::ST_ROUND:
        if ((is_xform && elem[1:0] == 2'd3) || (!is_xform && elem == 4'd15))
          state_next = is_xform ? hte_pkg::ST_DONE : hte_pkg::ST_COPY;
        else state_next = hte_pkg::ST_MAC;
      hte_pkg::ST_COPY: state_next = hte_pkg::ST_DONE;
      hte_pkg::ST_DONE: if (m_tready) state_next = hte_pkg::ST_IDLE;
      default: state_next = hte_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    m_tvalid = (state == hte_pkg::ST_DONE);
    m_tdata = {7'd0, flag, res[3], res[2], res[1], res[0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hte_pkg::ST_IDLE;
      for (int i = 0; i < 16; i++) mat[i] <= (i % 5 == 0) ? hte_pkg::OneValue : '0;
      prod_valid <= 1'b0;
      issue_done <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        hte_pkg::ST_IDLE: if (accept) begin
          req <= in_req;
          row <= s_tdata[5:4];
          col <= s_tdata[7:6];
          opa <= s_tdata[39:8];
          opb <= s_tdata[71:40];
          opc <= s_tdata[103:72];
          opd <= s_tdata[135:104];
          // negated sine clips when sine is the most negative value
          flag <= (in_req inside {hte_pkg::REQ_ROTX, hte_pkg::REQ_ROTY, hte_pkg::REQ_ROTZ})
                  && (s_tdata[71:40] == hte_pkg::WordMin);
          res[0] <= (in_req == hte_pkg::REQ_GET) ? mat[{s_tdata[5:4], s_tdata[7:6]}] : '0;
          for (int i = 1; i < 4; i++) res[i] <= '0;
          elem <= '0;
          kidx <= '0;
          acc <= '0;
          prod_valid <= 1'b0;
          issue_done <= 1'b0;
          is_xform <= (in_req == hte_pkg::REQ_TRANSFORM);
          case (in_req)
            hte_pkg::REQ_CLEAR: for (int i = 0; i < 16; i++) mat[i] <= '0;
            hte_pkg::REQ_IDENTITY:
              for (int i = 0; i < 16; i++) mat[i] <= (i % 5 == 0) ? hte_pkg::OneValue : '0;
            hte_pkg::REQ_SET: mat[{s_tdata[5:4], s_tdata[7:6]}] <= s_tdata[39:8];
            hte_pkg::REQ_TRANSPOSE:
              for (int i = 0; i < 4; i++)
                for (int k = 0; k < 4; k++) mat[i*4+k] <= mat[k*4+i];
            default: ;
          endcase
        end
        hte_pkg::ST_RECIP: if (recip_done) begin
          opd <= recip_val;
          flag <= recip_sat;
        end
        hte_pkg::ST_MAC: begin
          if (!issue_done) begin
            prod <= 64'(mul_a) * 64'(mul_b);
            kidx <= kidx + 2'd1;
            if (kidx == 2'd3) issue_done <= 1'b1;
          end
          prod_valid <= !issue_done;
          if (prod_valid) acc <= acc + hte_pkg::acc_t'(prod);
        end
        hte_pkg::ST_ROUND: begin
          if (rnd_sat) flag <= 1'b1;
          if (is_xform) res[elem[1:0]] <= rnd_word;
          else tmp[elem] <= rnd_word;
          acc <= '0;
          issue_done <= 1'b0;
          elem <= elem + 4'd1;
        end
        hte_pkg::ST_COPY: for (int i = 0; i < 16; i++) mat[i] <= tmp[i];
        default: ;
      endcase
    end
  end

  logic unused;
  assign unused = ^{row, col, recip_busy};

endmodule

// File: rtl/core/hte_recip.sv
`timescale 1ns / 1ps
module hte_recip (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  hte_pkg::word_t       d,
  output logic                 busy,
  output logic                 done,
  output hte_pkg::word_t       result,
  output logic                 sat
);

  localparam int NumW = 2 * hte_pkg::FracBits + 2;
  localparam int CntW = $clog2(NumW + 1);

  logic [NumW-1:0] num;
  logic [NumW-1:0] quo;
  logic [NumW:0] rem;
  logic [hte_pkg::WordWidth-1:0] mag;
  logic neg;
  logic [CntW-1:0] cnt;
  logic [NumW:0] rem_shift;
  logic [NumW+1:0] q_round;
  logic [NumW+1:0] signed_q;
  logic over;

  assign rem_shift = {rem[NumW-1:0], num[NumW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CntW'(NumW);
        mag <= d[hte_pkg::WordWidth-1] ? -d : d;
        neg <= d[hte_pkg::WordWidth-1];
        num <= NumW'(1) << (2 * hte_pkg::FracBits + 1);
        rem <= '0;
        quo <= '0;
      end else if (busy) begin
        num <= num << 1;
        if (rem_shift >= {{(NumW+1-hte_pkg::WordWidth){1'b0}}, mag}) begin
          rem <= rem_shift - {{(NumW+1-hte_pkg::WordWidth){1'b0}}, mag};
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[NumW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // quotient carries one extra bit for rounding half away from zero
  always_comb begin
    q_round = {2'b00, quo} + (NumW+2)'(1);
    q_round = q_round >> 1;
    signed_q = neg ? -q_round : q_round;
    over = 1'b0;
    result = signed_q[hte_pkg::WordWidth-1:0];
    if (!neg && q_round > (NumW+2)'(hte_pkg::WordMax)) begin
      over = 1'b1;
      result = hte_pkg::WordMax;
    end else if (neg && q_round > (NumW+2)'({1'b1, {(hte_pkg::WordWidth-1){1'b0}}})) begin
      over = 1'b1;
      result = hte_pkg::WordMin;
    end
    if (mag == '0) begin
      over = 1'b1;
      result = hte_pkg::WordMax;
    end
    sat = over;
  end

endmodule

// File: test/hte_checker.sv
`timescale 1ns / 1ps
module hte_checker
  import hte_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [135:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [135:0] m_tdata,
  output int           fail_count,
  output int           pending
);

  typedef struct packed {
    word_t x;
    word_t y;
    word_t z;
    word_t w;
    logic  sat;
  } point_res_t;

  word_t      mat [16];
  point_res_t result_q[$];
  bit         clip_hit;

  assign pending = result_q.size();

  function automatic word_t clip_word(input acc_t v);
    if (v > acc_t'(WordMax)) begin
      clip_hit = 1'b1;
      return WordMax;
    end
    if (v < acc_t'(WordMin)) begin
      clip_hit = 1'b1;
      return WordMin;
    end
    return word_t'(v);
  endfunction

  function automatic word_t round_sum(input acc_t s);
    acc_t r;
    r = (s + (acc_t'(1) <<< (FracBits - 1))) >>> FracBits;
    return clip_word(r);
  endfunction

  function automatic void load_identity();
    for (int i = 0; i < 16; i++) mat[i] = '0;
    mat[0] = OneValue;
    mat[5] = OneValue;
    mat[10] = OneValue;
    mat[15] = OneValue;
  endfunction

  function automatic void premultiply(input word_t l [16]);
    word_t t [16];
    acc_t  s;
    for (int i = 0; i < 4; i++)
      for (int j = 0; j < 4; j++) begin
        s = '0;
        for (int k = 0; k < 4; k++) s += acc_t'(l[i*4+k]) * acc_t'(mat[k*4+j]);
        t[i*4+j] = round_sum(s);
      end
    for (int i = 0; i < 16; i++) mat[i] = t[i];
  endfunction

  function automatic word_t recip(input word_t d);
    logic [63:0] mag;
    logic [63:0] q;
    if (d == 0) begin
      clip_hit = 1'b1;
      return WordMax;
    end
    mag = (d < 0) ? -64'(signed'(d)) : 64'(d);
    q = ((64'd1 << (2 * FracBits)) + mag / 2) / mag;
    return clip_word((d < 0) ? -acc_t'(q) : acc_t'(q));
  endfunction

  function automatic point_res_t run_request(input logic [135:0] t);
    req_t       req;
    logic [1:0] row, col;
    word_t      a, b, c, d, tmp;
    word_t      l [16];
    acc_t       s;
    word_t      p [4];
    word_t      q [4];
    point_res_t res;
    req = req_t'(t[3:0]);
    row = t[5:4];
    col = t[7:6];
    a = t[39:8];
    b = t[71:40];
    c = t[103:72];
    d = t[135:104];
    clip_hit = 1'b0;
    res = '0;
    for (int i = 0; i < 16; i++) l[i] = '0;
    l[0] = OneValue;
    l[5] = OneValue;
    l[10] = OneValue;
    l[15] = OneValue;
    case (req)
      REQ_CLEAR: for (int i = 0; i < 16; i++) mat[i] = '0;
      REQ_IDENTITY: load_identity();
      REQ_SET: mat[row*4+col] = a;
      REQ_GET: res.x = mat[row*4+col];
      REQ_TRANSLATE: begin
        l[3] = a; l[7] = b; l[11] = c;
        premultiply(l);
      end
      REQ_SCALE: begin
        l[0] = a; l[5] = b; l[10] = c;
        premultiply(l);
      end
      REQ_ROTX, REQ_ROTY, REQ_ROTZ: begin
        tmp = clip_word(-acc_t'(b));
        if (req == REQ_ROTX) begin
          l[5] = a; l[6] = tmp; l[9] = b; l[10] = a;
        end else if (req == REQ_ROTY) begin
          l[0] = a; l[2] = b; l[8] = tmp; l[10] = a;
        end else begin
          l[0] = a; l[1] = tmp; l[4] = b; l[5] = a;
        end
        premultiply(l);
      end
      REQ_SHEAR2D: begin
        l[1] = a; l[4] = b;
        premultiply(l);
      end
      REQ_SHEARZ: begin
        l[2] = a; l[6] = b;
        premultiply(l);
      end
      REQ_PERSP: begin
        l[14] = recip(a);
        l[15] = '0;
        premultiply(l);
      end
      REQ_TRANSFORM: begin
        p[0] = a; p[1] = b; p[2] = c; p[3] = d;
        for (int i = 0; i < 4; i++) begin
          s = '0;
          for (int k = 0; k < 4; k++) s += acc_t'(mat[i*4+k]) * acc_t'(p[k]);
          q[i] = round_sum(s);
        end
        res.x = q[0]; res.y = q[1]; res.z = q[2]; res.w = q[3];
      end
      default: begin
        for (int i = 0; i < 4; i++)
          for (int k = i + 1; k < 4; k++) begin
            tmp = mat[i*4+k];
            mat[i*4+k] = mat[k*4+i];
            mat[k*4+i] = tmp;
          end
      end
    endcase
    res.sat = clip_hit;
    return res;
  endfunction

  initial begin
    fail_count = 0;
    load_identity();
  end

  always @(posedge clk) begin
    point_res_t exp_r;
    word_t      ax, ay, az, aw;
    if (!rst) begin
      if (s_tvalid && s_tready && s_tdata[3:0] <= REQ_TRANSPOSE)
        result_q.push_back(run_request(s_tdata));
      if (m_tvalid && m_tready) begin
        ax = m_tdata[31:0];
        ay = m_tdata[63:32];
        az = m_tdata[95:64];
        aw = m_tdata[127:96];
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result transaction %h", $time, m_tdata);
          fail_count++;
        end else begin
          exp_r = result_q.pop_front();
          if (ax !== exp_r.x) begin
            $display("%0t: out_x expected %h actual %h", $time, exp_r.x, ax);
            fail_count++;
          end
          if (ay !== exp_r.y) begin
            $display("%0t: out_y expected %h actual %h", $time, exp_r.y, ay);
            fail_count++;
          end
          if (az !== exp_r.z) begin
            $display("%0t: out_z expected %h actual %h", $time, exp_r.z, az);
            fail_count++;
          end
          if (aw !== exp_r.w) begin
            $display("%0t: out_w expected %h actual %h", $time, exp_r.w, aw);
            fail_count++;
          end
          if (m_tdata[128] !== exp_r.sat) begin
            $display("%0t: saturated expected %b actual %b", $time, exp_r.sat, m_tdata[128]);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
module tb;
  import hte_pkg::*;

  localparam logic [3:0] ReqSpareLo = 4'd14;
  localparam logic [3:0] ReqSpareHi = 4'd15;
  localparam int         IdleLimit = 20000;

  logic         clk;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic [135:0] s_tdata = '0;
  logic         m_tready = 1'b0;
  wire          s_tready;
  wire          m_tvalid;
  wire  [135:0] m_tdata;
  int           fail_count;
  int           pending;
  int           burst_left = 0;
  int           idle_cycles = 0;
  int           stall_mode = 0;
  int           stall_left = 0;

  homogeneous_transform_engine_core DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  hte_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver stalls in stretches of its own
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 1) == 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [3:0] req, input logic [1:0] row, input logic [1:0] col,
                          input word_t a, input word_t b, input word_t c, input word_t d);
    if (burst_left == 0) begin
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    s_tdata <= {d, c, b, a, col, row, req};
    s_tvalid <= 1'b1;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    @(posedge clk);
    burst_left--;
  endtask

  function automatic word_t rand_operand();
    word_t v;
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 4))
          0: v = WordMin;
          1: v = WordMax;
          2: v = '0;
          3: v = OneValue;
          default: v = -OneValue;
        endcase
      end
      default: begin
        v = $urandom_range(0, 32'h0002_0000);
        if ($urandom_range(0, 1) == 1) v = -v;
      end
    endcase
    return v;
  endfunction

  initial begin
    logic [3:0] req;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed
    send_req(REQ_GET, 2'd0, 2'd0, '0, '0, '0, '0);
    send_req(REQ_TRANSFORM, 2'd0, 2'd0, WordMax, WordMin, WordMax, WordMin);
    send_req(REQ_SET, 2'd3, 2'd3, WordMax, '1, '1, '1);
    send_req(REQ_SET, 2'd0, 2'd3, WordMin, '0, '0, '0);
    send_req(REQ_GET, 2'd3, 2'd3, '1, '1, '1, '1);
    send_req(REQ_TRANSFORM, 2'd0, 2'd0, WordMax, WordMax, WordMax, WordMax);
    send_req(REQ_TRANSPOSE, 2'd0, 2'd0, '0, '0, '0, '0);
    send_req(REQ_GET, 2'd3, 2'd0, '0, '0, '0, '0);
    send_req(REQ_IDENTITY, 2'd0, 2'd0, '0, '0, '0, '0);
    send_req(REQ_TRANSLATE, 2'd0, 2'd0, OneValue, -OneValue, WordMax, '0);
    send_req(REQ_SCALE, 2'd0, 2'd0, 32'h0002_0000, 32'h0000_8000, WordMin, '0);
    send_req(REQ_ROTX, 2'd0, 2'd0, 32'h0000_b505, WordMin, '0, '0);
    send_req(REQ_ROTY, 2'd0, 2'd0, 32'h0000_b505, 32'h0000_b505, '0, '0);
    send_req(REQ_ROTZ, 2'd0, 2'd0, '0, OneValue, '0, '0);
    send_req(REQ_SHEAR2D, 2'd0, 2'd0, 32'h0000_4000, 32'hffff_c000, '0, '0);
    send_req(REQ_SHEARZ, 2'd0, 2'd0, 32'h0000_2000, 32'h0000_3000, '0, '0);
    send_req(REQ_PERSP, 2'd0, 2'd0, '0, WordMax, WordMax, WordMax);
    send_req(REQ_IDENTITY, 2'd0, 2'd0, '0, '0, '0, '0);
    send_req(REQ_PERSP, 2'd0, 2'd0, 32'd1, '0, '0, '0);
    send_req(REQ_IDENTITY, 2'd0, 2'd0, '0, '0, '0, '0);
    send_req(REQ_PERSP, 2'd0, 2'd0, WordMin, '0, '0, '0);
    send_req(REQ_TRANSFORM, 2'd0, 2'd0, OneValue, OneValue, OneValue, OneValue);
    send_req(ReqSpareLo, 2'd1, 2'd1, '1, '1, '1, '1);
    send_req(ReqSpareHi, 2'd2, 2'd2, '0, '0, '0, '0);
    send_req(REQ_CLEAR, 2'd0, 2'd0, '0, '0, '0, '0);
    send_req(REQ_GET, 2'd1, 2'd2, '0, '0, '0, '0);

    // random
    for (int n = 0; n < 650; n++) begin
      case ($urandom_range(0, 31))
        0: req = REQ_CLEAR;
        1, 2, 3: req = REQ_IDENTITY;
        4, 5, 6, 7: req = REQ_SET;
        8, 9, 10, 11: req = REQ_GET;
        12, 13: req = REQ_TRANSLATE;
        14, 15: req = REQ_SCALE;
        16: req = REQ_ROTX;
        17: req = REQ_ROTY;
        18: req = REQ_ROTZ;
        19: req = REQ_SHEAR2D;
        20: req = REQ_SHEARZ;
        21, 22: req = REQ_PERSP;
        23, 24, 25, 26, 27: req = REQ_TRANSFORM;
        28, 29: req = REQ_TRANSPOSE;
        default: req = ($urandom_range(0, 1) == 1) ? ReqSpareHi : ReqSpareLo;
      endcase
      send_req(req, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
               rand_operand(), rand_operand(), rand_operand(), rand_operand());
    end
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
